/* rtl/cptp_pkg.sv */
// ----------------------------------------------------------------------------
// cptp_pkg
// Shared types and constants for the single-plane polygon clipper.
// ----------------------------------------------------------------------------
package cptp_pkg;

    localparam int unsigned COORD_W    = 32;
    localparam int unsigned NORM_W     = 18;
    localparam int unsigned PD_W       = 32;
    localparam int unsigned EPS_W      = 16;
    localparam int unsigned DIST_W     = 36;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned STATUS_W   = 2;

    localparam logic signed [NORM_W-1:0] ONE_Q16      = 18'sd65536;
    localparam logic signed [NORM_W-1:0] NORM_Z_RESET = 18'sd65536;
    localparam logic [EPS_W-1:0]         EPS_RESET    = 16'd6554;

    localparam logic [STATUS_W-1:0] ST_CLIPPED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNCHANGED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ON   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_EPS    = 3'd5;

    localparam logic [1:0] COORD_X = 2'd0;
    localparam logic [1:0] COORD_Y = 2'd1;
    localparam logic [1:0] COORD_Z = 2'd2;

    typedef enum logic [1:0] {
        SIDE_AHEAD  = 2'd0,
        SIDE_BEHIND = 2'd1,
        SIDE_ON     = 2'd2
    } t_side;

    typedef enum logic [1:0] {
        OSEL_VERTEX = 2'd0,
        OSEL_SPLIT  = 2'd1,
        OSEL_NONE   = 2'd2
    } t_out_sel;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
        logic                      last_vertex;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      vertex_valid;
        logic [STATUS_W-1:0]       status;
        logic                      last_out;
    } t_out_item;

    typedef struct packed {
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic signed [PD_W-1:0]   plane_dist;
        logic                     keep_on_plane;
        logic [EPS_W-1:0]         on_tol;
    } t_cfg;

    typedef struct packed {
        logic                load_in;
        logic                store;
        logic                read;
        logic                split_start;
        logic [1:0]          split_coord;
        logic                out_load;
        t_out_sel            out_sel;
        logic [STATUS_W-1:0] out_status;
        logic                out_last;
    } t_dp_cmd;

    typedef struct packed {
        t_side new_side;
        t_side side_a;
        t_side side_b;
        logic  split_done;
        logic  out_free;
    } t_dp_stat;

endpackage

/* rtl/cptp_split.sv */
// ----------------------------------------------------------------------------
// cptp_split
// Serial split-point unit: p1 + d1*(p2-p1)/(d1-d2), quotient truncated
// toward zero, by shift-add multiply and restoring division.
// ----------------------------------------------------------------------------
module cptp_split (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [cptp_pkg::COORD_W-1:0] i_p1,
    input  logic signed [cptp_pkg::COORD_W-1:0] i_p2,
    input  logic signed [cptp_pkg::DIST_W-1:0]  i_d1,
    input  logic signed [cptp_pkg::DIST_W-1:0]  i_d2,
    output logic                                o_done,
    output logic signed [cptp_pkg::COORD_W-1:0] o_result
);

    localparam int unsigned MAG_W   = cptp_pkg::DIST_W;
    localparam int unsigned DELTA_W = cptp_pkg::COORD_W + 1;
    localparam int unsigned DEN_W   = cptp_pkg::DIST_W + 1;
    localparam int unsigned PROD_W  = MAG_W + DELTA_W;
    localparam int unsigned REM_W   = DEN_W + 1;
    localparam int unsigned CNT_W   = $clog2(PROD_W);

    typedef enum logic [1:0] {
        SP_IDLE,
        SP_MUL,
        SP_DIV,
        SP_DONE
    } t_sp_state;

    t_sp_state                 r_state;
    logic [MAG_W-1:0]          r_a;
    logic [DELTA_W-1:0]        r_b;
    logic [DEN_W-1:0]          r_den;
    logic                      r_neg;
    logic [PROD_W-1:0]         r_prod;
    logic [DEN_W-1:0]          r_rem;
    logic [DELTA_W-1:0]        r_q;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [cptp_pkg::COORD_W-1:0] r_p1;

    logic signed [DELTA_W:0]   delta_ext;
    logic signed [DEN_W:0]     den_ext;
    logic signed [DEN_W-1:0]   d1_ext;
    logic [MAG_W-1:0]          d1_mag;
    logic [DELTA_W-1:0]        delta_mag;
    logic [DEN_W-1:0]          den_mag;
    logic                      neg;
    logic [REM_W-1:0]          rem_t;
    logic [REM_W-1:0]          rem_s;
    logic signed [DELTA_W-1:0] sum;

    always_comb begin
        delta_ext = (DELTA_W+1)'(i_p2) - (DELTA_W+1)'(i_p1);
        den_ext   = (DEN_W+1)'(i_d1) - (DEN_W+1)'(i_d2);
        d1_ext    = DEN_W'(i_d1);
        d1_mag    = d1_ext[DEN_W-1] ? MAG_W'(-d1_ext) : MAG_W'(d1_ext);
        delta_mag = delta_ext[DELTA_W] ? DELTA_W'(-delta_ext) : DELTA_W'(delta_ext);
        den_mag   = den_ext[DEN_W] ? DEN_W'(-den_ext) : DEN_W'(den_ext);
        neg       = i_d1[cptp_pkg::DIST_W-1] ^ delta_ext[DELTA_W] ^ den_ext[DEN_W];
        rem_t     = {r_rem, r_prod[PROD_W-1]};
        rem_s     = rem_t - {1'b0, r_den};
        sum       = r_neg ? (DELTA_W'(r_p1) - signed'(r_q)) : (DELTA_W'(r_p1) + signed'(r_q));
    end

    assign o_done   = (r_state == SP_DONE);
    assign o_result = sum[cptp_pkg::COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SP_IDLE;
        end else begin
            unique case (r_state)
                SP_IDLE: begin
                    if (i_start) begin
                        r_a     <= d1_mag;
                        r_b     <= delta_mag;
                        r_den   <= den_mag;
                        r_neg   <= neg;
                        r_p1    <= i_p1;
                        r_prod  <= '0;
                        r_cnt   <= CNT_W'(DELTA_W - 1);
                        r_state <= SP_MUL;
                    end
                end
                SP_MUL: begin
                    r_prod <= (r_prod << 1) + (r_b[DELTA_W-1] ? PROD_W'(r_a) : '0);
                    r_b    <= r_b << 1;
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(PROD_W - 1);
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_state <= SP_DIV;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                SP_DIV: begin
                    if (!rem_s[REM_W-1]) begin
                        r_rem <= rem_s[DEN_W-1:0];
                        r_q   <= {r_q[DELTA_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_t[DEN_W-1:0];
                        r_q   <= {r_q[DELTA_W-2:0], 1'b0};
                    end
                    r_prod <= r_prod << 1;
                    if (r_cnt == '0) begin
                        r_state <= SP_DONE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                SP_DONE: begin
                    r_state <= SP_IDLE;
                end
                default: begin
                    r_state <= SP_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == SP_IDLE))
        else $error("Split unit started while busy.");

endmodule

/* rtl/cptp_dp.sv */
// ----------------------------------------------------------------------------
// cptp_dp
// Datapath: plane distance, vertex memory, split unit and output register.
// ----------------------------------------------------------------------------
module cptp_dp #(
    parameter int unsigned MAX_VERTS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cptp_pkg::t_cfg            i_cfg,
    input  cptp_pkg::t_in_item        i_in,
    input  cptp_pkg::t_dp_cmd         i_cmd,
    output cptp_pkg::t_dp_stat        o_stat,
    input  logic [$clog2(MAX_VERTS)-1:0] i_wr_addr,
    input  logic [$clog2(MAX_VERTS)-1:0] i_rd_addr_a,
    input  logic [$clog2(MAX_VERTS)-1:0] i_rd_addr_b,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output cptp_pkg::t_out_item       o_out
);

    localparam int unsigned MUL_W  = cptp_pkg::COORD_W + cptp_pkg::NORM_W;
    localparam int unsigned SUM_W  = MUL_W + 2;
    localparam int unsigned DIST_W = cptp_pkg::DIST_W;
    localparam int unsigned CW     = cptp_pkg::COORD_W;

    typedef struct packed {
        logic signed [CW-1:0]     x;
        logic signed [CW-1:0]     y;
        logic signed [CW-1:0]     z;
        logic signed [DIST_W-1:0] d;
        cptp_pkg::t_side          side;
    } t_entry;

    t_entry                  r_mem [MAX_VERTS];
    t_entry                  r_rd_a;
    t_entry                  r_rd_b;
    logic signed [CW-1:0]    r_vx;
    logic signed [CW-1:0]    r_vy;
    logic signed [CW-1:0]    r_vz;
    logic signed [MUL_W-1:0] r_px;
    logic signed [MUL_W-1:0] r_py;
    logic signed [MUL_W-1:0] r_pz;
    logic signed [CW-1:0]    r_sx;
    logic signed [CW-1:0]    r_sy;
    logic signed [CW-1:0]    r_sz;
    logic                    r_out_valid;
    cptp_pkg::t_out_item     r_out;

    logic signed [SUM_W-1:0]  sum;
    logic signed [DIST_W-1:0] dot;
    logic signed [DIST_W:0]   d_full;
    logic signed [DIST_W:0]   eps_s;
    cptp_pkg::t_side          new_side;
    t_entry                   wr_entry;
    logic signed [CW-1:0]     sp_p1;
    logic signed [CW-1:0]     sp_p2;
    logic signed [cptp_pkg::NORM_W-1:0] sp_norm;
    logic signed [CW-1:0]     neg_pd;
    logic signed [CW-1:0]     snap;
    logic                     sp_done;
    logic signed [CW-1:0]     sp_result;
    logic                     out_free;
    cptp_pkg::t_out_item      next_out;

    always_comb begin
        sum    = SUM_W'(r_px) + SUM_W'(r_py) + SUM_W'(r_pz);
        dot    = sum[SUM_W-1:16];
        d_full = (DIST_W+1)'(dot) - (DIST_W+1)'(i_cfg.plane_dist);
        eps_s  = signed'((DIST_W+1)'(i_cfg.on_tol));
        if (d_full > eps_s) begin
            new_side = cptp_pkg::SIDE_AHEAD;
        end else if (d_full < -eps_s) begin
            new_side = cptp_pkg::SIDE_BEHIND;
        end else begin
            new_side = cptp_pkg::SIDE_ON;
        end
        wr_entry.x    = r_vx;
        wr_entry.y    = r_vy;
        wr_entry.z    = r_vz;
        wr_entry.d    = d_full[DIST_W-1:0];
        wr_entry.side = new_side;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_vx <= i_in.vertex_x;
            r_vy <= i_in.vertex_y;
            r_vz <= i_in.vertex_z;
            r_px <= MUL_W'(i_in.vertex_x) * MUL_W'(i_cfg.normal_x);
            r_py <= MUL_W'(i_in.vertex_y) * MUL_W'(i_cfg.normal_y);
            r_pz <= MUL_W'(i_in.vertex_z) * MUL_W'(i_cfg.normal_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[i_wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    always_comb begin
        case (i_cmd.split_coord)
            cptp_pkg::COORD_X: begin
                sp_p1   = r_rd_a.x;
                sp_p2   = r_rd_b.x;
                sp_norm = i_cfg.normal_x;
            end
            cptp_pkg::COORD_Y: begin
                sp_p1   = r_rd_a.y;
                sp_p2   = r_rd_b.y;
                sp_norm = i_cfg.normal_y;
            end
            default: begin
                sp_p1   = r_rd_a.z;
                sp_p2   = r_rd_b.z;
                sp_norm = i_cfg.normal_z;
            end
        endcase
        neg_pd = -i_cfg.plane_dist;
        if (sp_norm == cptp_pkg::ONE_Q16) begin
            snap = i_cfg.plane_dist;
        end else if (sp_norm == -cptp_pkg::ONE_Q16) begin
            snap = neg_pd;
        end else begin
            snap = sp_result;
        end
    end

    cptp_split u_split (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.split_start),
        .i_p1     (sp_p1),
        .i_p2     (sp_p2),
        .i_d1     (r_rd_a.d),
        .i_d2     (r_rd_b.d),
        .o_done   (sp_done),
        .o_result (sp_result)
    );

    always_ff @(posedge i_clk) begin
        if (sp_done) begin
            case (i_cmd.split_coord)
                cptp_pkg::COORD_X: r_sx <= snap;
                cptp_pkg::COORD_Y: r_sy <= snap;
                default:           r_sz <= snap;
            endcase
        end
    end

    always_comb begin
        case (i_cmd.out_sel)
            cptp_pkg::OSEL_VERTEX: begin
                next_out.out_x        = r_rd_a.x;
                next_out.out_y        = r_rd_a.y;
                next_out.out_z        = r_rd_a.z;
                next_out.vertex_valid = 1'b1;
            end
            cptp_pkg::OSEL_SPLIT: begin
                next_out.out_x        = r_sx;
                next_out.out_y        = r_sy;
                next_out.out_z        = r_sz;
                next_out.vertex_valid = 1'b1;
            end
            default: begin
                next_out.out_x        = '0;
                next_out.out_y        = '0;
                next_out.out_z        = '0;
                next_out.vertex_valid = 1'b0;
            end
        endcase
        next_out.status   = i_cmd.out_status;
        next_out.last_out = i_cmd.out_last;
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out <= next_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign o_stat.new_side   = new_side;
    assign o_stat.side_a     = r_rd_a.side;
    assign o_stat.side_b     = r_rd_b.side;
    assign o_stat.split_done = sp_done;
    assign o_stat.out_free   = out_free;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("Output register overwritten while a beat was stalled.");

endmodule

/* rtl/cptp_ctrl.sv */
// ----------------------------------------------------------------------------
// cptp_ctrl
// Controller: vertex loading, side counts, status decision and the walk
// over the stored polygon.
// ----------------------------------------------------------------------------
module cptp_ctrl #(
    parameter int unsigned MAX_VERTS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_last_vertex,
    input  logic                         i_keep_on_plane,
    output cptp_pkg::t_dp_cmd            o_cmd,
    input  cptp_pkg::t_dp_stat           i_stat,
    output logic [$clog2(MAX_VERTS)-1:0] o_wr_addr,
    output logic [$clog2(MAX_VERTS)-1:0] o_rd_addr_a,
    output logic [$clog2(MAX_VERTS)-1:0] o_rd_addr_b
);

    localparam int unsigned IW    = $clog2(MAX_VERTS);
    localparam int unsigned CW    = $clog2(MAX_VERTS + 1);
    localparam int unsigned TW    = CW + 1;
    localparam int          LIMIT = (MAX_VERTS + 4 < 64) ? MAX_VERTS + 4 : 64;

    typedef enum logic [3:0] {
        S_LOAD,
        S_DIST,
        S_DECIDE,
        S_SINGLE,
        S_RD,
        S_EVAL,
        S_EMITV,
        S_SPLIT,
        S_SWAIT,
        S_EMITS,
        S_NEXT,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [CW-1:0]                 r_cnt;
    logic [CW-1:0]                 r_front;
    logic [CW-1:0]                 r_back;
    logic [CW-1:0]                 r_cross;
    cptp_pkg::t_side               r_first_side;
    cptp_pkg::t_side               r_prev_side;
    logic                          r_ovf;
    logic                          r_last;
    logic                          r_unchanged;
    logic [cptp_pkg::STATUS_W-1:0] r_single_status;
    logic [IW-1:0]                 r_idx;
    logic [TW-1:0]                 r_total;
    logic [TW-1:0]                 r_emitted;
    logic [1:0]                    r_coord;

    logic          accept;
    logic          wrap;
    logic [TW-1:0] total;
    logic          idx_last;
    logic          pair_cross;

    function automatic logic is_crossing(cptp_pkg::t_side a, cptp_pkg::t_side b);
        is_crossing = ((a == cptp_pkg::SIDE_AHEAD) && (b == cptp_pkg::SIDE_BEHIND)) ||
                      ((a == cptp_pkg::SIDE_BEHIND) && (b == cptp_pkg::SIDE_AHEAD));
    endfunction

    always_comb begin
        accept     = i_in_valid && (r_state == S_LOAD);
        wrap       = is_crossing(r_prev_side, r_first_side);
        total      = TW'(r_cnt) - TW'(r_back) + TW'(r_cross) + TW'(wrap);
        idx_last   = (CW'(r_idx) == (r_cnt - 1'b1));
        pair_cross = is_crossing(i_stat.side_a, i_stat.side_b);
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_wr_addr   = r_cnt[IW-1:0];
    assign o_rd_addr_a = r_idx;
    assign o_rd_addr_b = idx_last ? '0 : r_idx + 1'b1;

    always_comb begin
        o_cmd             = '0;
        o_cmd.out_sel     = cptp_pkg::OSEL_NONE;
        o_cmd.split_coord = r_coord;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load_in = accept;
            end
            S_DIST: begin
                o_cmd.store = (r_cnt < CW'(MAX_VERTS));
            end
            S_SINGLE: begin
                o_cmd.out_load   = i_stat.out_free;
                o_cmd.out_status = r_single_status;
                o_cmd.out_last   = 1'b1;
            end
            S_RD: begin
                o_cmd.read = 1'b1;
            end
            S_EMITV: begin
                o_cmd.out_load   = i_stat.out_free;
                o_cmd.out_sel    = cptp_pkg::OSEL_VERTEX;
                o_cmd.out_status = r_unchanged ? cptp_pkg::ST_UNCHANGED
                                               : cptp_pkg::ST_CLIPPED;
                o_cmd.out_last   = r_unchanged ? idx_last
                                               : (r_emitted + 1'b1 == r_total);
            end
            S_SPLIT: begin
                o_cmd.split_start = 1'b1;
            end
            S_EMITS: begin
                o_cmd.out_load   = i_stat.out_free;
                o_cmd.out_sel    = cptp_pkg::OSEL_SPLIT;
                o_cmd.out_status = cptp_pkg::ST_CLIPPED;
                o_cmd.out_last   = (r_emitted + 1'b1 == r_total);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_LOAD;
            r_cnt           <= '0;
            r_front         <= '0;
            r_back          <= '0;
            r_cross         <= '0;
            r_first_side    <= cptp_pkg::SIDE_ON;
            r_prev_side     <= cptp_pkg::SIDE_ON;
            r_ovf           <= 1'b0;
            r_last          <= 1'b0;
            r_unchanged     <= 1'b0;
            r_single_status <= cptp_pkg::ST_EMPTY;
            r_idx           <= '0;
            r_total         <= '0;
            r_emitted       <= '0;
            r_coord         <= cptp_pkg::COORD_X;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        r_last  <= i_last_vertex;
                        r_state <= S_DIST;
                    end
                end
                S_DIST: begin
                    if (r_cnt < CW'(MAX_VERTS)) begin
                        if (i_stat.new_side == cptp_pkg::SIDE_AHEAD) begin
                            r_front <= r_front + 1'b1;
                        end
                        if (i_stat.new_side == cptp_pkg::SIDE_BEHIND) begin
                            r_back <= r_back + 1'b1;
                        end
                        if (r_cnt == '0) begin
                            r_first_side <= i_stat.new_side;
                        end else if (is_crossing(r_prev_side, i_stat.new_side)) begin
                            r_cross <= r_cross + 1'b1;
                        end
                        r_prev_side <= i_stat.new_side;
                        r_cnt       <= r_cnt + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    r_state <= r_last ? S_DECIDE : S_LOAD;
                end
                S_DECIDE: begin
                    r_idx     <= '0;
                    r_emitted <= '0;
                    r_total   <= total;
                    if (r_ovf) begin
                        r_single_status <= cptp_pkg::ST_OVERFLOW;
                        r_state         <= S_SINGLE;
                    end else if ((i_keep_on_plane && r_front == '0 && r_back == '0) ||
                                 (r_front != '0 && r_back == '0)) begin
                        r_unchanged <= 1'b1;
                        r_state     <= S_RD;
                    end else if (r_front == '0) begin
                        r_single_status <= cptp_pkg::ST_EMPTY;
                        r_state         <= S_SINGLE;
                    end else if (int'(total) > LIMIT) begin
                        r_single_status <= cptp_pkg::ST_OVERFLOW;
                        r_state         <= S_SINGLE;
                    end else begin
                        r_unchanged <= 1'b0;
                        r_state     <= S_RD;
                    end
                end
                S_SINGLE: begin
                    if (i_stat.out_free) begin
                        r_state <= S_DONE;
                    end
                end
                S_RD: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_coord <= cptp_pkg::COORD_X;
                    if (r_unchanged || i_stat.side_a != cptp_pkg::SIDE_BEHIND) begin
                        r_state <= S_EMITV;
                    end else if (pair_cross) begin
                        r_state <= S_SPLIT;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_EMITV: begin
                    if (i_stat.out_free) begin
                        r_emitted <= r_emitted + 1'b1;
                        r_state   <= (!r_unchanged && pair_cross) ? S_SPLIT : S_NEXT;
                    end
                end
                S_SPLIT: begin
                    r_state <= S_SWAIT;
                end
                S_SWAIT: begin
                    if (i_stat.split_done) begin
                        if (r_coord == cptp_pkg::COORD_Z) begin
                            r_state <= S_EMITS;
                        end else begin
                            r_coord <= r_coord + 1'b1;
                            r_state <= S_SPLIT;
                        end
                    end
                end
                S_EMITS: begin
                    if (i_stat.out_free) begin
                        r_emitted <= r_emitted + 1'b1;
                        r_state   <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (idx_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_DONE: begin
                    r_cnt   <= '0;
                    r_front <= '0;
                    r_back  <= '0;
                    r_cross <= '0;
                    r_ovf   <= 1'b0;
                    r_state <= S_LOAD;
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_VERTS))
        else $error("Vertex count ran past the store depth.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (TW'(r_front) + TW'(r_back)) <= TW'(r_cnt))
        else $error("Side counts exceed the vertex count.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && !r_unchanged && o_cmd.out_sel != cptp_pkg::OSEL_NONE)
        |-> (r_emitted < r_total))
        else $error("Clipped polygon emitted more points than counted.");

endmodule

/* rtl/clip_polygon_to_plane_top.sv */
// ----------------------------------------------------------------------------
// clip_polygon_to_plane_top
// Clips one convex polygon against a single plane and returns the part on
// the front side, with split points at each front/back crossing.
//
// Input beats carry one Q16.16 vertex each; the beat with last_vertex set
// closes the polygon. Loading a vertex registers its products first, then
// computes the distance and writes the store. After the last vertex the block
// walks the stored polygon; each split point comes from the serial
// multiply-divide unit, which runs once for each coordinate (33 multiply
// steps and 69 divide steps). No input is accepted during the walk. Results
// leave through an output register, so a stalled output beat holds its
// payload and the walk pauses until it is taken; the next polygon's first
// vertex is taken while the final result still waits. The configuration port
// is always ready; it is to be written only while the block is idle, which
// the block itself does not enforce. Reset restores the default plane (normal
// along +z, distance 0, epsilon 6554) and clears the polygon counts.
// ----------------------------------------------------------------------------
module clip_polygon_to_plane_top #(
    parameter int unsigned MAX_VERTS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  cptp_pkg::t_in_item                   i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output cptp_pkg::t_out_item                  o_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [cptp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cptp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int unsigned IW = $clog2(MAX_VERTS);

    cptp_pkg::t_cfg     r_cfg;
    cptp_pkg::t_dp_cmd  cmd;
    cptp_pkg::t_dp_stat stat;
    logic               in_ready;
    logic [IW-1:0]      wr_addr;
    logic [IW-1:0]      rd_addr_a;
    logic [IW-1:0]      rd_addr_b;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_x      <= '0;
            r_cfg.normal_y      <= '0;
            r_cfg.normal_z      <= cptp_pkg::NORM_Z_RESET;
            r_cfg.plane_dist    <= '0;
            r_cfg.keep_on_plane <= 1'b0;
            r_cfg.on_tol        <= cptp_pkg::EPS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cptp_pkg::CFG_NORMAL_X: r_cfg.normal_x <= i_cfg_data[cptp_pkg::NORM_W-1:0];
                cptp_pkg::CFG_NORMAL_Y: r_cfg.normal_y <= i_cfg_data[cptp_pkg::NORM_W-1:0];
                cptp_pkg::CFG_NORMAL_Z: r_cfg.normal_z <= i_cfg_data[cptp_pkg::NORM_W-1:0];
                cptp_pkg::CFG_PLANE_D:  r_cfg.plane_dist <= i_cfg_data[cptp_pkg::PD_W-1:0];
                cptp_pkg::CFG_KEEP_ON:  r_cfg.keep_on_plane <= i_cfg_data[0];
                cptp_pkg::CFG_ON_EPS:   r_cfg.on_tol <= i_cfg_data[cptp_pkg::EPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cptp_ctrl #(
        .MAX_VERTS (MAX_VERTS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (in_ready),
        .i_last_vertex   (i_in.last_vertex),
        .i_keep_on_plane (r_cfg.keep_on_plane),
        .o_cmd           (cmd),
        .i_stat          (stat),
        .o_wr_addr       (wr_addr),
        .o_rd_addr_a     (rd_addr_a),
        .o_rd_addr_b     (rd_addr_b)
    );

    cptp_dp #(
        .MAX_VERTS (MAX_VERTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_wr_addr   (wr_addr),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

/* tb/clip_polygon_to_plane_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clip_polygon_to_plane_top_test
// Self-checking bench for the single-plane polygon clipper. Polygons of random
// and hand-picked shapes are sent over several plane settings. A predictor in
// this file computes the expected output beats. A monitor compares every output
// beat, field by field, while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module clip_polygon_to_plane_top_test;

    localparam int unsigned MAX_VERTS = 32;
    localparam int unsigned MAX_OUT   = 64;

    localparam logic [cptp_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [cptp_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    cptp_pkg::t_in_item              i_in;
    logic                            o_out_valid;
    logic                            i_out_stall;
    cptp_pkg::t_out_item             o_out;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [cptp_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [cptp_pkg::CFG_DATA_W-1:0] i_cfg_data;

    clip_polygon_to_plane_top #(.MAX_VERTS(MAX_VERTS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Plane settings and polygon state mirrored by the predictor.
    logic signed [cptp_pkg::NORM_W-1:0] plane_nx, plane_ny, plane_nz;
    logic signed [cptp_pkg::PD_W-1:0]   plane_d;
    logic                               keep_on;
    logic [cptp_pkg::EPS_W-1:0]         on_eps;

    longint          poly_x [MAX_VERTS];
    longint          poly_y [MAX_VERTS];
    longint          poly_z [MAX_VERTS];
    longint          poly_dist [MAX_VERTS];
    cptp_pkg::t_side poly_side [MAX_VERTS];
    int              poly_count, front_total, back_total;
    bit              too_many;

    cptp_pkg::t_in_item  vertex_queue [$];
    cptp_pkg::t_out_item expected_beats [$];

    int send_idle_pct;
    int recv_idle_pct;
    bit start_hold;
    logic hold_active;
    int mismatch_count;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic cptp_pkg::t_out_item make_beat(longint x, longint y, longint z,
                                                      logic vld,
                                                      logic [cptp_pkg::STATUS_W-1:0] st,
                                                      logic lst);
        cptp_pkg::t_out_item r;
        r.out_x        = x[31:0];
        r.out_y        = y[31:0];
        r.out_z        = z[31:0];
        r.vertex_valid = vld;
        r.status       = st;
        r.last_out     = lst;
        return r;
    endfunction

    function automatic longint split_point(longint p1, longint p2, longint d1, longint d2,
                                           logic signed [cptp_pkg::NORM_W-1:0] n);
        logic signed [127:0] num;
        logic signed [127:0] den;
        logic signed [127:0] quo;
        logic signed [31:0]  neg_d;
        if (n == cptp_pkg::ONE_Q16) begin
            return longint'(plane_d);
        end
        if (n == -cptp_pkg::ONE_Q16) begin
            neg_d = -plane_d;
            return longint'(neg_d);
        end
        num = 128'(d1) * 128'(p2 - p1);
        den = 128'(d1 - d2);
        quo = num / den;
        return p1 + longint'(quo);
    endfunction

    function automatic void clear_polygon();
        poly_count  = 0;
        front_total = 0;
        back_total  = 0;
        too_many    = 1'b0;
    endfunction

    function automatic void clip_vertex(cptp_pkg::t_in_item it);
        longint              sum, offset, eps;
        cptp_pkg::t_side     s;
        cptp_pkg::t_out_item kept [$];
        int                  j;
        if (poly_count < MAX_VERTS) begin
            sum = longint'(it.vertex_x) * longint'(plane_nx)
                + longint'(it.vertex_y) * longint'(plane_ny)
                + longint'(it.vertex_z) * longint'(plane_nz);
            offset = (sum >>> 16) - longint'(plane_d);
            eps    = longint'(on_eps);
            if (offset > eps) begin
                s = cptp_pkg::SIDE_AHEAD;
            end else if (offset < -eps) begin
                s = cptp_pkg::SIDE_BEHIND;
            end else begin
                s = cptp_pkg::SIDE_ON;
            end
            poly_x[poly_count]    = longint'(it.vertex_x);
            poly_y[poly_count]    = longint'(it.vertex_y);
            poly_z[poly_count]    = longint'(it.vertex_z);
            poly_dist[poly_count] = offset;
            poly_side[poly_count] = s;
            if (s == cptp_pkg::SIDE_AHEAD) front_total++;
            if (s == cptp_pkg::SIDE_BEHIND) back_total++;
            poly_count++;
        end else begin
            too_many = 1'b1;
        end
        if (!it.last_vertex) return;
        if (too_many) begin
            expected_beats.push_back(make_beat(0, 0, 0, 1'b0, cptp_pkg::ST_OVERFLOW, 1'b1));
        end else if ((keep_on && front_total == 0 && back_total == 0) ||
                     (front_total != 0 && back_total == 0)) begin
            for (int i = 0; i < poly_count; i++)
                expected_beats.push_back(make_beat(poly_x[i], poly_y[i], poly_z[i], 1'b1,
                                                   cptp_pkg::ST_UNCHANGED,
                                                   i + 1 == poly_count));
        end else if (front_total == 0) begin
            expected_beats.push_back(make_beat(0, 0, 0, 1'b0, cptp_pkg::ST_EMPTY, 1'b1));
        end else begin
            for (int i = 0; i < poly_count; i++) begin
                j = (i + 1 < poly_count) ? i + 1 : 0;
                if (poly_side[i] != cptp_pkg::SIDE_BEHIND)
                    kept.push_back(make_beat(poly_x[i], poly_y[i], poly_z[i], 1'b1,
                                             cptp_pkg::ST_CLIPPED, 1'b0));
                if (poly_side[i] != cptp_pkg::SIDE_ON && poly_side[j] != cptp_pkg::SIDE_ON &&
                    poly_side[j] != poly_side[i])
                    kept.push_back(make_beat(
                        split_point(poly_x[i], poly_x[j], poly_dist[i], poly_dist[j], plane_nx),
                        split_point(poly_y[i], poly_y[j], poly_dist[i], poly_dist[j], plane_ny),
                        split_point(poly_z[i], poly_z[j], poly_dist[i], poly_dist[j], plane_nz),
                        1'b1, cptp_pkg::ST_CLIPPED, 1'b0));
            end
            if (kept.size() > MAX_VERTS + 4 || kept.size() > MAX_OUT) begin
                expected_beats.push_back(make_beat(0, 0, 0, 1'b0, cptp_pkg::ST_OVERFLOW,
                                                   1'b1));
            end else begin
                kept[kept.size() - 1].last_out = 1'b1;
                foreach (kept[k]) expected_beats.push_back(kept[k]);
            end
        end
        clear_polygon();
    endfunction

    // Input driver.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) clip_vertex(i_in);
            if (!i_in_valid || !o_in_stall) begin
                if (vertex_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in       <= vertex_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor.
    always @(posedge i_clk) begin
        cptp_pkg::t_out_item exp_beat;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected output beat %p", o_out);
                end else begin
                    exp_beat = expected_beats.pop_front();
                    if (o_out.out_x !== exp_beat.out_x || o_out.out_y !== exp_beat.out_y ||
                        o_out.out_z !== exp_beat.out_z ||
                        o_out.vertex_valid !== exp_beat.vertex_valid ||
                        o_out.status !== exp_beat.status ||
                        o_out.last_out !== exp_beat.last_out) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Mismatch: expected %p, got %p", exp_beat, o_out);
                    end
                end
            end
            i_out_stall <= hold_active || ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        hold_active = 1'b0;
        wait (start_hold);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (1500) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    task automatic write_reg(logic [cptp_pkg::CFG_IDX_W-1:0] idx,
                             logic [cptp_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            cptp_pkg::CFG_NORMAL_X: plane_nx = data[cptp_pkg::NORM_W-1:0];
            cptp_pkg::CFG_NORMAL_Y: plane_ny = data[cptp_pkg::NORM_W-1:0];
            cptp_pkg::CFG_NORMAL_Z: plane_nz = data[cptp_pkg::NORM_W-1:0];
            cptp_pkg::CFG_PLANE_D:  plane_d  = data[cptp_pkg::PD_W-1:0];
            cptp_pkg::CFG_KEEP_ON:  keep_on  = data[0];
            cptp_pkg::CFG_ON_EPS:   on_eps   = data[cptp_pkg::EPS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_plane(int nx, int ny, int nz, int pd, bit keep, int eps);
        write_reg(cptp_pkg::CFG_NORMAL_X, nx);
        write_reg(cptp_pkg::CFG_NORMAL_Y, ny);
        write_reg(cptp_pkg::CFG_NORMAL_Z, nz);
        write_reg(cptp_pkg::CFG_PLANE_D, pd);
        write_reg(cptp_pkg::CFG_KEEP_ON, {31'd0, keep});
        write_reg(cptp_pkg::CFG_ON_EPS, eps);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (vertex_queue.size() > 0 || i_in_valid || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic void push_vertex(int x, int y, int z, bit lst);
        cptp_pkg::t_in_item it;
        it.vertex_x    = x;
        it.vertex_y    = y;
        it.vertex_z    = z;
        it.last_vertex = lst;
        vertex_queue.push_back(it);
    endfunction

    function automatic int rand_coord(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mode 0: z in steps around the plane, 1: moderate coordinates, 2: full range.
    function automatic void random_polygon(int mode);
        int n, r, z;
        r = $urandom_range(99);
        n = (r < 70) ? $urandom_range(3, 6) : (r < 85) ? $urandom_range(1, 2) :
            (r < 95) ? $urandom_range(7, MAX_VERTS) : $urandom_range(MAX_VERTS + 1,
                                                                      MAX_VERTS + 4);
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: begin
                    z = (int'($urandom_range(0, 6)) - 3) * 6000;
                    push_vertex(rand_coord(1 << 20), rand_coord(1 << 20), z, i == n - 1);
                end
                1: push_vertex(rand_coord(1 << 18), rand_coord(1 << 18), rand_coord(1 << 18),
                               i == n - 1);
                default: push_vertex($urandom, $urandom, $urandom, i == n - 1);
            endcase
        end
    endfunction

    function automatic void random_batch(int mode, int items);
        int start;
        start = vertex_queue.size();
        while (vertex_queue.size() - start < items) random_polygon(mode);
    endfunction

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        i_out_stall    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        start_hold     = 1'b0;
        mismatch_count = 0;
        send_idle_pct  = 8;
        recv_idle_pct  = 53;
        plane_nx = '0;
        plane_ny = '0;
        plane_nz = cptp_pkg::NORM_Z_RESET;
        plane_d  = '0;
        keep_on  = 1'b0;
        on_eps   = cptp_pkg::EPS_RESET;
        clear_polygon();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset plane: z = 0, epsilon about 0.1.
        push_vertex(0, 0, 65536, 0);
        push_vertex(65536, 0, 65536, 0);
        push_vertex(0, 65536, 65536, 1);
        push_vertex(0, 0, -65536, 0);
        push_vertex(65536, 0, -65536, 0);
        push_vertex(0, 65536, -65536, 1);
        push_vertex(0, 0, 100, 0);
        push_vertex(65536, 0, -100, 0);
        push_vertex(0, 65536, 0, 1);
        push_vertex(0, 0, 131072, 0);
        push_vertex(131072, 0, -65536, 0);
        push_vertex(0, 131072, 0, 0);
        push_vertex(-65536, 0, -131072, 1);
        push_vertex(5, 7, 65536, 1);
        push_vertex(-65536, 3, 65536, 0);
        push_vertex(65536, 9, -196608, 1);
        push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        push_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        push_vertex(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1);
        wait_drained();
        set_plane(0, 0, 65536, 0, 1'b1, 6554);
        push_vertex(0, 0, 10, 0);
        push_vertex(65536, 0, -10, 0);
        push_vertex(0, 65536, 0, 1);
        wait_drained();
        write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_B, 32'h1234_5678);

        // Long receiver hold while the sender keeps offering polygons.
        set_plane(0, 0, 65536, 0, 1'b0, 6554);
        random_batch(0, 40);
        start_hold = 1'b1;
        wait_drained();

        set_plane(65536, 0, 0, 32768, 1'b0, 0);
        random_batch(1, 35);
        wait_drained();
        set_plane(-65536, 65536, -65536, -40000, 1'b1, 65535);
        random_batch(1, 35);
        wait_drained();

        send_idle_pct = 53;
        recv_idle_pct = 8;
        set_plane(rand_coord(65536), rand_coord(65536), rand_coord(65536),
                  rand_coord(1 << 17), 1'b0, $urandom_range(0, 20000));
        random_batch(1, 35);
        wait_drained();
        set_plane(32'h1FFFF, 32'h20000, 32'h0FFFF, 32'h8000_0000, 1'b1, 65535);
        random_batch(2, 30);
        wait_drained();
        set_plane(0, 0, -65536, 32'h7FFF_FFFF, 1'b0, 0);
        random_batch(2, 30);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_plane(0, 0, 65536, 0, 1'b1, 6554);
        random_batch(0, 35);
        wait_drained();
        set_plane(rand_coord(65536), rand_coord(65536), 65536,
                  rand_coord(1 << 16), 1'b0, $urandom_range(0, 65535));
        random_batch(1, 35);
        wait_drained();

        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
rtl/cptp_pkg.sv
rtl/cptp_split.sv
rtl/cptp_dp.sv
rtl/cptp_ctrl.sv
rtl/clip_polygon_to_plane_top.sv
tb/clip_polygon_to_plane_top_test.sv
